[src/dstq_pkg.sv]
//------------------------------------------------------------------------------
// dstq_pkg: shared types and constants of the sorted timer queue
// Command and result kind codes, controller/datapath command and status.
//------------------------------------------------------------------------------
`default_nettype none
package dstq_pkg;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_SWEEP  = 2'd2;

	localparam logic [2:0] KIND_ADDED   = 3'd0;
	localparam logic [2:0] KIND_REJECT  = 3'd1;
	localparam logic [2:0] KIND_CANCEL  = 3'd2;
	localparam logic [2:0] KIND_EXPIRED = 3'd3;
	localparam logic [2:0] KIND_DONE    = 3'd4;

	// datapath operations requested by the controller
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_LOAD   = 3'd1; // capture input beat
	localparam logic [2:0] OP_ALLOC  = 3'd2; // pop free stack, write stores
	localparam logic [2:0] OP_SCAN   = 3'd3; // advance insert position
	localparam logic [2:0] OP_INSERT = 3'd4; // shift order, place slot
	localparam logic [2:0] OP_CANCEL = 3'd5;
	localparam logic [2:0] OP_POP    = 3'd6; // drop head, free slot

	typedef struct packed {
		logic [2:0] op;
		logic       emit;      // load output register
		logic [2:0] emit_kind;
		logic       emit_last;
	} dstq_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       reject;    // add cannot proceed
		logic       scan_done; // insert position found
		logic       empty;
		logic       head_live;
		logic       head_due;  // head deadline <= now
		logic       out_busy;  // output register still holds a beat
	} dstq_sts_t;

endpackage
`default_nettype wire

[src/dstq_datapath.sv]
//------------------------------------------------------------------------------
// dstq_datapath: stores, sorted order, free stack and output register
// Executes one controller operation per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module dstq_datapath #(
	parameter int CAPACITY = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  dstq_pkg::dstq_cmd_t cmd,
	output dstq_pkg::dstq_sts_t sts,
	input  wire  [100:0]        in_data,
	output logic [47:0]         out_data,
	output logic                out_valid,
	input  wire                 out_ready
);
	import dstq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [IW-1:0] order_q [CAPACITY];
	logic [31:0]   deadline_q [CAPACITY];
	logic [31:0]   tag_q [CAPACITY];
	logic [CAPACITY-1:0] live_q;
	logic [IW-1:0] free_q [CAPACITY];
	logic [CW-1:0] free_top_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] pos_q;
	logic [IW-1:0] slot_q;
	logic [31:0]   dl_q;

	logic [1:0]  command_q;
	logic [31:0] now_q;
	logic [30:0] delay_q;
	logic [31:0] tag_in_q;
	logic [3:0]  slot_id_q;

	logic [IW-1:0] head;
	logic [IW-1:0] pos_slot;

	assign head     = order_q[0];
	assign pos_slot = order_q[pos_q[IW-1:0]];

	assign sts.command   = command_q;
	assign sts.reject    = (delay_q == 31'd0) || (free_top_q == '0) ||
	                       (count_q >= CW'(CAPACITY));
	assign sts.scan_done = (pos_q == count_q) || (deadline_q[pos_slot] > dl_q);
	assign sts.empty     = (count_q == '0);
	assign sts.head_live = live_q[head];
	assign sts.head_due  = (deadline_q[head] <= now_q);
	assign sts.out_busy  = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q     <= '0;
			free_top_q <= CW'(CAPACITY);
			count_q    <= '0;
			pos_q      <= '0;
			out_valid  <= 1'b0;
			for (int i = 0; i < CAPACITY; i++) begin
				free_q[i] <= IW'(i);
			end
		end else begin
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (cmd.op)
				OP_ALLOC: begin
					free_top_q <= free_top_q - 1'b1;
					pos_q      <= '0;
					live_q[free_q[free_top_q[IW-1:0] - 1'b1]] <= 1'b1;
				end
				OP_SCAN: begin
					pos_q <= pos_q + 1'b1;
				end
				OP_INSERT: begin
					for (int i = 1; i < CAPACITY; i++) begin
						if (CW'(i) > pos_q && CW'(i) <= count_q) begin
							order_q[i] <= order_q[i-1];
						end
					end
					order_q[pos_q[IW-1:0]] <= slot_q;
					count_q <= count_q + 1'b1;
				end
				OP_CANCEL: begin
					if ({1'b0, slot_id_q} < 5'(CAPACITY)) begin
						live_q[slot_id_q[IW-1:0]] <= 1'b0;
					end
				end
				OP_POP: begin
					for (int i = 0; i < CAPACITY - 1; i++) begin
						order_q[i] <= order_q[i+1];
					end
					count_q <= count_q - 1'b1;
					live_q[head] <= 1'b0;
					free_q[free_top_q[IW-1:0]] <= head;
					free_top_q <= free_top_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				command_q <= in_data[1:0];
				now_q     <= in_data[33:2];
				delay_q   <= in_data[64:34];
				tag_in_q  <= in_data[96:65];
				slot_id_q <= in_data[100:97];
			end
			OP_ALLOC: begin
				slot_q <= free_q[free_top_q[IW-1:0] - 1'b1];
				dl_q   <= now_q + {1'b0, delay_q};
				deadline_q[free_q[free_top_q[IW-1:0] - 1'b1]] <= now_q + {1'b0, delay_q};
				tag_q[free_q[free_top_q[IW-1:0] - 1'b1]]      <= tag_in_q;
			end
			default: begin
			end
		endcase
		if (cmd.emit) begin
			out_data[2:0] <= cmd.emit_kind;
			out_data[47]  <= cmd.emit_last;
			case (cmd.emit_kind)
				KIND_ADDED: begin
					out_data[6:3]  <= 4'(slot_q);
					out_data[38:7] <= '0;
				end
				KIND_CANCEL: begin
					out_data[6:3]  <= slot_id_q;
					out_data[38:7] <= '0;
				end
				KIND_EXPIRED: begin
					out_data[6:3]  <= 4'(head);
					out_data[38:7] <= tag_q[head];
				end
				default: begin
					out_data[6:3]  <= '0;
					out_data[38:7] <= '0;
				end
			endcase
			out_data[46:39] <= '0;
		end
	end
endmodule
`default_nettype wire

[src/dstq_ctrl.sv]
//------------------------------------------------------------------------------
// dstq_ctrl: command sequencer of the sorted timer queue
// Steps add, cancel and sweep through datapath operations.
//------------------------------------------------------------------------------
`default_nettype none
module dstq_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [1:0]          in_command,
	input  dstq_pkg::dstq_sts_t sts,
	output dstq_pkg::dstq_cmd_t cmd
);
	import dstq_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DEC   = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_SWEEP = 3'd3;
	localparam logic [2:0] ST_EXP   = 3'd4;

	logic [2:0] state_q, state_d;
	logic [4:0] nexp_q, nexp_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		nexp_d  = nexp_q;
		cmd     = '{op: OP_NONE, emit: 1'b0, emit_kind: KIND_DONE, emit_last: 1'b1};
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = (in_command == CMD_ADD || in_command == CMD_CANCEL ||
					           in_command == CMD_SWEEP) ? ST_DEC : ST_IDLE;
				end
			end
			ST_DEC: begin
				if (!sts.out_busy) begin
					case (sts.command)
						CMD_ADD: begin
							if (sts.reject) begin
								cmd.emit = 1'b1;
								cmd.emit_kind = KIND_REJECT;
								state_d = ST_IDLE;
							end else begin
								cmd.op = OP_ALLOC;
								state_d = ST_SCAN;
							end
						end
						CMD_CANCEL: begin
							cmd.op = OP_CANCEL;
							cmd.emit = 1'b1;
							cmd.emit_kind = KIND_CANCEL;
							state_d = ST_IDLE;
						end
						default: begin
							nexp_d  = '0;
							state_d = ST_SWEEP;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					cmd.op = OP_INSERT;
					cmd.emit = 1'b1;
					cmd.emit_kind = KIND_ADDED;
					state_d = ST_IDLE;
				end else begin
					cmd.op = OP_SCAN;
				end
			end
			ST_SWEEP: begin
				if (!sts.out_busy) begin
					if (sts.empty || (sts.head_live &&
					    (!sts.head_due || nexp_q == 5'd16))) begin
						cmd.emit = 1'b1;
						state_d = ST_IDLE;
					end else if (!sts.head_live) begin
						cmd.op = OP_POP;
					end else begin
						cmd.emit = 1'b1;
						cmd.emit_kind = KIND_EXPIRED;
						cmd.emit_last = 1'b0;
						state_d = ST_EXP;
					end
				end
			end
			ST_EXP: begin
				cmd.op  = OP_POP;
				nexp_d  = nexp_q + 1'b1;
				state_d = ST_SWEEP;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nexp_q  <= '0;
		end else begin
			state_q <= state_d;
			nexp_q  <= nexp_d;
		end
	end
endmodule
`default_nettype wire

[src/deadline_sorted_timer_queue_top.sv]
//------------------------------------------------------------------------------
// deadline_sorted_timer_queue_top: sorted timer queue with CAPACITY slots
//
// Slave stream s_axis_* takes one command beat, the command code on
// s_axis_tuser; master stream m_axis_* returns result beats, the result
// kind on m_axis_tuser, last one of each command flagged by m_axis_tlast.
// Add: picks a slot from a LIFO free stack, deadline = now + delay, and
// inserts it after equal deadlines. Reply: added (slot) or rejected.
// Cancel: clears the live mark, replies cancel done.
// Sweep: drops cancelled heads, emits up to 16 due heads with their tag,
// ends with a done beat.
// Add scans the sorted order linearly for the insert position, one entry
// per cycle. One command is in work at a time; s_axis_tready is high
// only while idle.
// Reset: empty queue, all slots free, slot CAPACITY-1 on top of the stack.
// A stalled master side holds the output register; the sequencer waits
// before producing the next beat, nothing is lost.
//------------------------------------------------------------------------------
`default_nettype none
module deadline_sorted_timer_queue_top #(
	parameter int CAPACITY = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// now_time[31:0], delay[62:32], tag[94:63], slot_id[98:95]
	input  wire  [103:0] s_axis_tdata,
	// command[1:0]
	input  wire  [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// result_slot[3:0], tag_out[35:4]
	output logic [39:0]  m_axis_tdata,
	// kind[2:0]
	output logic [2:0]   m_axis_tuser,
	output logic         m_axis_tlast
);
	import dstq_pkg::*;

	dstq_cmd_t   cmd;
	dstq_sts_t   sts;
	logic [47:0] out_data;

	dstq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_command (s_axis_tuser),
		.sts        (sts),
		.cmd        (cmd)
	);

	dstq_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   ({s_axis_tdata[98:0], s_axis_tuser}),
		.out_data  (out_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

	// out_data: kind[2:0], slot[6:3], tag[38:7], zeros, last[47]
	assign m_axis_tuser = out_data[2:0];
	assign m_axis_tdata = out_data[42:3];
	assign m_axis_tlast = out_data[47];
endmodule
`default_nettype wire

[src/dstq_checker.sv]
//------------------------------------------------------------------------------
// dstq_port_checks: port-level checks of the timer queue
// Bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none
module dstq_port_checks (
	input wire         clk,
	input wire         arst_n,
	input wire         s_axis_tvalid,
	input wire         s_axis_tready,
	input wire [1:0]   s_axis_tuser,
	input wire         m_axis_tvalid,
	input wire         m_axis_tready,
	input wire [39:0]  m_axis_tdata,
	input wire [2:0]   m_axis_tuser,
	input wire         m_axis_tlast
);
	import dstq_pkg::*;

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result beat changed under stall");

	// only expired beats are not last
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == KIND_EXPIRED)
		else $error("non-last beat of wrong kind");

	// tag is zero except on expiry
	a_tag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_EXPIRED |-> m_axis_tdata[35:4] == '0)
		else $error("tag on non-expiry beat");

	// accepting a known command takes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_ADD ||
		s_axis_tuser == CMD_CANCEL || s_axis_tuser == CMD_SWEEP) |=> !s_axis_tready)
		else $error("ready after accept");
endmodule

bind deadline_sorted_timer_queue_top dstq_port_checks u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
